// ----- design/cspg_pkg.sv -----
// Shared types and constants for the column-to-span generator.
// Used by cspg_step and column_to_span_generator; depends on nothing.
package cspg_pkg;

    localparam int ROW_W = 6;
    localparam int X_W   = 9;

    typedef logic [ROW_W-1:0] row_t;
    typedef logic [X_W-1:0]   xpos_t;
    typedef logic [1:0]       phase_t;

    // Pass order within one column.
    localparam phase_t PH_CLOSE_TOP = 2'd0;
    localparam phase_t PH_OPEN_TOP  = 2'd1;
    localparam phase_t PH_CLOSE_BOT = 2'd2;
    localparam phase_t PH_OPEN_BOT  = 2'd3;

    // Action chosen by the step unit for the current cycle.
    typedef struct packed {
        logic emit;
        logic mark;
        logic last;
        logic done;
    } step_ctrl_t;

endpackage

// ----- design/column_to_span_generator.sv -----
// Top level of the column-to-span generator: sequencer, row start memory, output register.
// Depends on cspg_pkg and cspg_step.
//
// One column beat is taken, then the block handles one row per cycle while no
// span waits on out_stall: each closed row leaves as one span beat and each
// opened row writes its start x into the row start memory. No new column is
// accepted until the step unit finds no work left for the current one. The
// pace is set by the single step unit, which compares the extents and moves
// one row per cycle, and by the one-port row start memory. Spans are read
// from the memory with a registered read; the memory needs no clearing after
// reset.
module column_to_span_generator #(
    parameter int ROWS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               first,
    input  cspg_pkg::xpos_t    column_x,
    input  cspg_pkg::row_t     top_row,
    input  cspg_pkg::row_t     bottom_row,
    output logic               out_valid,
    input  logic               out_stall,
    output cspg_pkg::row_t     row,
    output cspg_pkg::xpos_t    start_x,
    output cspg_pkg::xpos_t    end_x,
    output logic               is_last
);
    import cspg_pkg::*;

    localparam int DEPTH = (ROWS > (1 << ROW_W)) ? (1 << ROW_W) : ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam row_t EMPTY_TOP = row_t'(DEPTH - 1);

    logic       busy_reg;
    phase_t     phase_reg;
    row_t       prev_top_reg;
    row_t       prev_bot_reg;
    row_t       pt_reg;
    row_t       pb_reg;
    row_t       nt_reg;
    row_t       nb_reg;
    xpos_t      x_reg;
    logic       out_valid_reg;
    row_t       out_row_reg;
    xpos_t      out_end_reg;
    logic       out_last_reg;
    xpos_t      rd_data_reg;
    logic       rd_zero_reg;
    xpos_t      mem [DEPTH];

    phase_t     phase_next;
    row_t       pt_next;
    row_t       pb_next;
    row_t       nt_next;
    row_t       nb_next;
    row_t       step_row;
    step_ctrl_t ctrl;
    logic       accept;
    logic       emit_ok;
    logic       row_in_range;
    logic       act;

    assign in_stall = busy_reg;
    assign accept   = in_valid && !busy_reg;
    assign emit_ok  = !out_valid_reg || !out_stall;
    assign act      = busy_reg && !ctrl.done;

    // Step unit working on the held extents.
    cspg_step u_step (
        .phase      (phase_reg),
        .pt         (pt_reg),
        .pb         (pb_reg),
        .nt         (nt_reg),
        .nb         (nb_reg),
        .emit_ok    (emit_ok && busy_reg),
        .phase_next (phase_next),
        .pt_next    (pt_next),
        .pb_next    (pb_next),
        .nt_next    (nt_next),
        .nb_next    (nb_next),
        .step_row   (step_row),
        .ctrl       (ctrl)
    );

    // Rows past the memory depth have no stored start.
    assign row_in_range = {1'b0, step_row} < (ROW_W + 1)'(DEPTH);

    // Sequencer control and previous column extent.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            phase_reg     <= PH_CLOSE_TOP;
            prev_top_reg  <= EMPTY_TOP;
            prev_bot_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg     <= 1'b1;
                phase_reg    <= PH_CLOSE_TOP;
                prev_top_reg <= top_row;
                prev_bot_reg <= bottom_row;
            end
            else if (busy_reg)
            begin
                busy_reg  <= !ctrl.done;
                phase_reg <= phase_next;
            end
            out_valid_reg <= (busy_reg && ctrl.emit) || (out_valid_reg && out_stall);
        end
    end

    // Working extents of the column in progress.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pt_reg <= first ? EMPTY_TOP : prev_top_reg;
            pb_reg <= first ? row_t'(0) : prev_bot_reg;
            nt_reg <= top_row;
            nb_reg <= bottom_row;
            x_reg  <= column_x;
        end
        else if (act)
        begin
            pt_reg <= pt_next;
            pb_reg <= pb_next;
            nt_reg <= nt_next;
            nb_reg <= nb_next;
        end
    end

    // Span output register; start x comes from the registered memory read.
    always_ff @(posedge clk)
    begin
        if (busy_reg && ctrl.emit)
        begin
            out_row_reg  <= step_row;
            out_end_reg  <= x_reg;
            out_last_reg <= ctrl.last;
            rd_zero_reg  <= !row_in_range;
        end
    end

    // Row start memory: one access per cycle, write on open, read on close.
    always_ff @(posedge clk)
    begin
        if (busy_reg && ctrl.mark && row_in_range)
        begin
            mem[step_row[AW-1:0]] <= x_reg;
        end
        if (busy_reg && ctrl.emit)
        begin
            rd_data_reg <= mem[step_row[AW-1:0]];
        end
    end

    assign out_valid = out_valid_reg;
    assign row       = out_row_reg;
    assign start_x   = rd_zero_reg ? xpos_t'(0) : rd_data_reg;
    assign end_x     = out_end_reg;
    assign is_last   = out_last_reg;

    // A span is launched only into a free or draining output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && ctrl.emit) |-> (!out_valid_reg || !out_stall))
        else $error("span launched over a waiting span");

    // The memory port never sees a write and a read in one cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && ctrl.emit && ctrl.mark))
        else $error("row start memory written and read together");

    // Once the step unit finds no work, the block is ready next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && ctrl.done) |=> !in_stall)
        else $error("sequencer did not release after finishing a column");

    // A last span is always the one that ends the column's work.
    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && ctrl.emit && ctrl.last) |=> !(busy_reg && ctrl.emit))
        else $error("span emitted after a last span of the same column");

endmodule

// ----- design/cspg_step.sv -----
// Shared compare and step unit: picks one row action per cycle.
// Depends on cspg_pkg.
module cspg_step (
    input  cspg_pkg::phase_t     phase,
    input  cspg_pkg::row_t       pt,
    input  cspg_pkg::row_t       pb,
    input  cspg_pkg::row_t       nt,
    input  cspg_pkg::row_t       nb,
    input  logic                 emit_ok,
    output cspg_pkg::phase_t     phase_next,
    output cspg_pkg::row_t       pt_next,
    output cspg_pkg::row_t       pb_next,
    output cspg_pkg::row_t       nt_next,
    output cspg_pkg::row_t       nb_next,
    output cspg_pkg::row_t       step_row,
    output cspg_pkg::step_ctrl_t ctrl
);
    import cspg_pkg::*;

    logic c_close_top;
    logic c_open_top;
    logic c_close_bot;
    logic c_open_bot;
    row_t pt_inc;
    row_t pb_dec;

    // Loop conditions of the four passes on the current extents.
    assign c_close_top = (pt < nt) && (pt <= pb);
    assign c_open_top  = (nt < pt) && (nt <= nb);
    assign c_close_bot = (pb > nb) && (pb >= pt);
    assign c_open_bot  = (nb > pb) && (nb >= nt);

    assign pt_inc = pt + row_t'(1);
    assign pb_dec = pb - row_t'(1);

    // Take the first pass at or after the current phase that still has work.
    always_comb
    begin
        phase_next = phase;
        pt_next    = pt;
        pb_next    = pb;
        nt_next    = nt;
        nb_next    = nb;
        step_row   = pt;
        ctrl       = '0;
        if ((phase == PH_CLOSE_TOP) && c_close_top)
        begin
            step_row = pt;
            if (emit_ok)
            begin
                ctrl.emit = 1'b1;
                pt_next   = pt_inc;
                // Last span when neither closing pass continues with the new top.
                ctrl.last = !((pt_inc < nt) && (pt_inc <= pb))
                         && !((pb > nb) && (pb >= pt_inc));
            end
        end
        else if ((phase <= PH_OPEN_TOP) && c_open_top)
        begin
            phase_next = PH_OPEN_TOP;
            step_row   = nt;
            ctrl.mark  = 1'b1;
            nt_next    = nt + row_t'(1);
        end
        else if ((phase <= PH_CLOSE_BOT) && c_close_bot)
        begin
            phase_next = PH_CLOSE_BOT;
            step_row   = pb;
            if (emit_ok)
            begin
                ctrl.emit = 1'b1;
                pb_next   = pb_dec;
                ctrl.last = !((pb_dec > nb) && (pb_dec >= pt));
            end
        end
        else if (c_open_bot)
        begin
            phase_next = PH_OPEN_BOT;
            step_row   = nb;
            ctrl.mark  = 1'b1;
            nb_next    = nb - row_t'(1);
        end
        else
        begin
            ctrl.done = 1'b1;
        end
    end

endmodule

// ----- verif/column_to_span_generator_tb.sv -----
// Testbench for column_to_span_generator: drives plane columns and checks every span beat
// against an in-file span predictor or typed spans. Depends on cspg_pkg and the RTL only.
module column_to_span_generator_tb;
    import cspg_pkg::*;

    localparam int ROWS           = 64;
    localparam int ROW_MAX        = ROWS - 1;
    localparam int RANDOM_COLUMNS = 180;
    localparam int LONG_HOLD      = 300;
    localparam int IDLE_LIMIT     = 2000;
    localparam int DRAIN_CYCLES   = 80;

    // How a directed row gets its expectation.
    typedef enum logic [1:0] {
        EXP_MODEL,
        EXP_NONE,
        EXP_SPAN
    } exp_kind_t;

    typedef struct packed {
        logic  first;
        xpos_t column_x;
        row_t  top_row;
        row_t  bottom_row;
    } column_t;

    typedef struct packed {
        row_t  row;
        xpos_t start_x;
        xpos_t end_x;
        logic  is_last;
    } span_t;

    typedef struct packed {
        column_t   col;
        exp_kind_t kind;
        span_t     span;
    } plan_row_t;

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_stall;
    logic  first;
    xpos_t column_x;
    row_t  top_row;
    row_t  bottom_row;
    logic  out_valid;
    logic  out_stall;
    row_t  row;
    xpos_t start_x;
    xpos_t end_x;
    logic  is_last;

    // Predictor state: the last extent and the recorded start of each row.
    row_t  last_top;
    row_t  last_bottom;
    xpos_t row_start_x [ROWS];

    span_t     expected_spans [$];
    plan_row_t directed_plan [$];
    int        columns_sent;
    int        spans_checked = 0;
    int        error_count = 0;
    int        burst_left;
    int        idle_cycles;

    column_to_span_generator #(
        .ROWS(ROWS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .first     (first),
        .column_x  (column_x),
        .top_row   (top_row),
        .bottom_row(bottom_row),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .row       (row),
        .start_x   (start_x),
        .end_x     (end_x),
        .is_last   (is_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Works out the spans that one column closes and records the rows it opens.
    function automatic void predict_spans(input column_t c, ref span_t spans[$]);
        int    pt;
        int    pb;
        int    nt;
        int    nb;
        span_t s;
        pt = c.first ? ROW_MAX : int'(last_top);
        pb = c.first ? 0 : int'(last_bottom);
        nt = int'(c.top_row);
        nb = int'(c.bottom_row);
        last_top    = c.top_row;
        last_bottom = c.bottom_row;
        spans.delete();
        s.end_x   = c.column_x;
        s.is_last = 1'b0;
        // Rows closing at the top leave in ascending order.
        while (pt < nt && pt <= pb)
        begin
            s.row     = row_t'(pt);
            s.start_x = row_start_x[pt];
            spans.push_back(s);
            pt++;
        end
        while (nt < pt && nt <= nb)
        begin
            row_start_x[nt] = c.column_x;
            nt++;
        end
        // Rows closing at the bottom leave in descending order.
        while (pb > nb && pb >= pt)
        begin
            s.row     = row_t'(pb);
            s.start_x = row_start_x[pb];
            spans.push_back(s);
            pb--;
        end
        while (nb > pb && nb >= nt)
        begin
            row_start_x[nb] = c.column_x;
            nb--;
        end
        if (spans.size() > 0)
            spans[spans.size() - 1].is_last = 1'b1;
    endfunction

    function automatic int walk_row(input int r);
        int v;
        v = r + int'($urandom_range(0, 6)) - 3;
        return (v < 0) ? 0 : ((v > ROW_MAX) ? ROW_MAX : v);
    endfunction

    function automatic void add_plan_row(input logic f, input int x, input int t, input int b,
                                         input exp_kind_t k, input int r = 0,
                                         input int s = 0, input int e = 0);
        plan_row_t p;
        p.col.first      = f;
        p.col.column_x   = xpos_t'(x);
        p.col.top_row    = row_t'(t);
        p.col.bottom_row = row_t'(b);
        p.kind           = k;
        p.span.row       = row_t'(r);
        p.span.start_x   = xpos_t'(s);
        p.span.end_x     = xpos_t'(e);
        p.span.is_last   = 1'b1;
        directed_plan.push_back(p);
    endfunction

    // Offers one column beat, with a random gap between bursts, and books its spans once taken.
    task automatic offer_column(input column_t c, input exp_kind_t kind, input span_t typed);
        int    gap;
        span_t spans [$];
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        first      <= c.first;
        column_x   <= c.column_x;
        top_row    <= c.top_row;
        bottom_row <= c.bottom_row;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predict_spans(c, spans);
        case (kind)
            EXP_MODEL: foreach (spans[i]) expected_spans.push_back(spans[i]);
            EXP_SPAN:  expected_spans.push_back(typed);
            default:   ;
        endcase
        columns_sent++;
    endtask

    // Stimulus: reset, the directed table, then random planes, then the drain.
    initial
    begin : stimulus
        column_t c;
        span_t   no_span;
        int      x0;
        int      len;
        int      t;
        int      b;
        int      pick;
        in_valid    <= 1'b0;
        first       <= 1'b0;
        column_x    <= '0;
        top_row     <= '0;
        bottom_row  <= '0;
        rst_n       <= 1'b0;
        last_top     = row_t'(ROW_MAX);
        last_bottom  = '0;
        columns_sent = 0;
        burst_left   = 0;
        no_span      = '0;

        // first, x, top, bottom, expectation
        add_plan_row(1'b1,   0,  0, 63, EXP_NONE);
        add_plan_row(1'b0,   1,  0, 63, EXP_NONE);
        add_plan_row(1'b0,   2, 10, 50, EXP_MODEL);
        add_plan_row(1'b0,   3, 63,  0, EXP_MODEL);
        add_plan_row(1'b1, 255, 63, 63, EXP_NONE);
        add_plan_row(1'b0, 256, 63,  0, EXP_SPAN, 63, 255, 256);
        add_plan_row(1'b1, 100,  0,  0, EXP_NONE);
        add_plan_row(1'b0, 101,  1,  1, EXP_SPAN, 0, 100, 101);
        add_plan_row(1'b0, 102,  1, 63, EXP_MODEL);
        add_plan_row(1'b0, 103,  0, 63, EXP_MODEL);
        add_plan_row(1'b1, 104,  5,  5, EXP_NONE);
        add_plan_row(1'b0, 105,  6,  0, EXP_SPAN, 5, 104, 105);
        add_plan_row(1'b1,  10, 10, 20, EXP_MODEL);
        add_plan_row(1'b0,  11, 30, 40, EXP_MODEL);
        add_plan_row(1'b0,  12,  5,  8, EXP_MODEL);
        add_plan_row(1'b0,  13,  9,  8, EXP_MODEL);
        add_plan_row(1'b1,  20,  0, 63, EXP_MODEL);
        add_plan_row(1'b0,  21, 63,  0, EXP_MODEL);
        add_plan_row(1'b1,   0,  0, 63, EXP_MODEL);
        add_plan_row(1'b0,   1, 31, 32, EXP_MODEL);
        add_plan_row(1'b0,   2, 32, 31, EXP_MODEL);
        add_plan_row(1'b0,   3,  0, 63, EXP_MODEL);
        add_plan_row(1'b0,   4, 63,  0, EXP_MODEL);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
            offer_column(directed_plan[i].col, directed_plan[i].kind, directed_plan[i].span);

        // Mostly well-formed planes ended by a flush column; some stray or abandoned ones.
        while (columns_sent < directed_plan.size() + RANDOM_COLUMNS)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                c.first      = 1'($urandom_range(0, 1));
                c.column_x   = xpos_t'($urandom_range(0, 256));
                c.top_row    = row_t'($urandom_range(0, ROW_MAX));
                c.bottom_row = row_t'($urandom_range(0, ROW_MAX));
                offer_column(c, EXP_MODEL, no_span);
            end
            x0  = $urandom_range(0, 220);
            len = $urandom_range(1, 30);
            if (x0 + len > 256)
                len = 256 - x0;
            t = $urandom_range(0, ROW_MAX);
            b = $urandom_range(t, ROW_MAX);
            for (int i = 0; i < len; i++)
            begin
                if (i > 0)
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 6)
                    begin
                        t = walk_row(t);
                        b = walk_row(b);
                    end
                    else if (pick == 6)
                    begin
                        t = $urandom_range(0, ROW_MAX);
                        b = $urandom_range(0, ROW_MAX);
                    end
                    else if (pick == 7)
                    begin
                        t = $urandom_range(1, ROW_MAX);
                        b = $urandom_range(0, t - 1);
                    end
                end
                c.first      = (i == 0);
                c.column_x   = xpos_t'(x0 + i);
                c.top_row    = row_t'(t);
                c.bottom_row = row_t'(b);
                offer_column(c, EXP_MODEL, no_span);
            end
            if ($urandom_range(0, 9) != 0)
            begin
                c.first      = 1'b0;
                c.column_x   = xpos_t'(x0 + len);
                c.top_row    = row_t'($urandom_range(1, ROW_MAX));
                c.bottom_row = row_t'($urandom_range(0, c.top_row - 1));
                offer_column(c, EXP_MODEL, no_span);
            end
        end
        in_valid <= 1'b0;

        while (expected_spans.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d columns (%0d directed) and checked %0d span beats.",
                 columns_sent, directed_plan.size(), spans_checked);
        $display("The output was held off once for %0d cycles while columns kept coming.",
                 LONG_HOLD);
        if (error_count == 0 && expected_spans.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Output stall: random patterns in segments, and one long hold-off mid-run.
    initial
    begin : receiver
        int  mode;
        int  seg_len;
        bit  held;
        out_stall <= 1'b0;
        held = 1'b0;
        @(posedge clk);
        forever
        begin
            if (!held && columns_sent >= 60)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            mode    = $urandom_range(0, 3);
            seg_len = $urandom_range(5, 40);
            for (int i = 0; i < seg_len; i++)
            begin
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= 1'($urandom_range(0, 1));
                    default: out_stall <= (i % 3 != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // Compares each span beat with the oldest expectation.
    always @(posedge clk)
    begin
        span_t exp_span;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (expected_spans.size() == 0)
            begin
                $error("span beat with nothing expected: row %0d start_x %0d end_x %0d",
                       row, start_x, end_x);
                error_count++;
            end
            else
            begin
                exp_span = expected_spans.pop_front();
                spans_checked++;
                if (row !== exp_span.row)
                begin
                    $error("row: expected %0d, got %0d", exp_span.row, row);
                    error_count++;
                end
                if (start_x !== exp_span.start_x)
                begin
                    $error("start_x: expected %0d, got %0d", exp_span.start_x, start_x);
                    error_count++;
                end
                if (end_x !== exp_span.end_x)
                begin
                    $error("end_x: expected %0d, got %0d", exp_span.end_x, end_x);
                    error_count++;
                end
                if (is_last !== exp_span.is_last)
                begin
                    $error("is_last: expected %0d, got %0d", exp_span.is_last, is_last);
                    error_count++;
                end
            end
        end
    end

    // Ends the run when neither channel moves a beat for too long.
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no beat moved for %0d cycles.", IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

// ----- files.f -----
design/cspg_pkg.sv
design/cspg_step.sv
design/column_to_span_generator.sv
verif/column_to_span_generator_tb.sv
